>>> hdl/cmup_pkg.sv
package cmup_pkg;

    // Field widths
    localparam int COMP_BITS  = 16;
    localparam int COORD_BITS = 16;

    // Face coordinate of the cube face center, and the saturation code
    localparam logic [COORD_BITS-1:0] CENTRE    = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_TOP = {COORD_BITS{1'b1}};

    // Stages: one front stage, one stage per quotient bit, one output stage
    localparam int DIV_STAGES = COORD_BITS;

    // Input item
    typedef struct packed {
        logic signed [COMP_BITS-1:0] vec_x;
        logic signed [COMP_BITS-1:0] vec_y;
        logic signed [COMP_BITS-1:0] vec_z;
    } vec_t;

    // Result item
    typedef struct packed {
        logic [COORD_BITS-1:0] tex_u;
        logic [COORD_BITS-1:0] tex_v;
        logic                  zero_vector;
    } tex_t;

    // Divider pipeline stage contents
    typedef struct packed {
        logic [COMP_BITS-1:0]  den;
        logic [COMP_BITS-1:0]  rem_u;
        logic [COMP_BITS-1:0]  rem_v;
        logic [COORD_BITS-1:0] quo_u;
        logic [COORD_BITS-1:0] quo_v;
        logic                  neg_u;
        logic                  neg_v;
        logic                  zero;
    } div_t;

endpackage

>>> hdl/cube_map_uv_projection_top.sv
// Cube map face coordinate projection.
//
// Input channel vec (vec_valid/vec_ready) carries one direction vector of
// three signed components. Output channel tex (tex_valid/tex_ready) returns
// one result per vector: the two face coordinates, 32768 at the face center
// and saturated at the top code, plus a flag for an all-zero vector, which
// maps to the center.
//
// One stage picks the dominant axis and the two numerators, one stage per
// quotient bit runs a restoring division step for both coordinates, and the
// output stage maps the quotients onto the coordinate range. One vector per
// cycle is sustained while the receiver keeps tex_ready high.
//
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver holds tex_ready low, the result waits in the output
// register, and earlier stages keep advancing into empty slots; input is
// refused only once every stage holds an item.
module cube_map_uv_projection_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vec_valid,
    output logic             vec_ready,
    input  cmup_pkg::vec_t   vec,
    output logic             tex_valid,
    input  logic             tex_ready,
    output cmup_pkg::tex_t   tex
);

    localparam int LAST = cmup_pkg::DIV_STAGES;

    cmup_pkg::div_t stage_reg [0:LAST];
    logic           valid_reg [0:LAST];
    cmup_pkg::div_t front_next;
    cmup_pkg::tex_t out_reg;
    cmup_pkg::tex_t out_next;
    logic           out_valid_reg;
    logic           adv [0:LAST+1];

    // One restoring division step on both coordinates
    function automatic cmup_pkg::div_t div_step(cmup_pkg::div_t s, logic first);
        cmup_pkg::div_t        r;
        logic [cmup_pkg::COMP_BITS-1:0] tu;
        logic [cmup_pkg::COMP_BITS-1:0] tv;
        logic                  bu;
        logic                  bv;
        r  = s;
        tu = first ? s.rem_u : {s.rem_u[cmup_pkg::COMP_BITS-2:0], 1'b0};
        tv = first ? s.rem_v : {s.rem_v[cmup_pkg::COMP_BITS-2:0], 1'b0};
        bu = (tu >= s.den);
        bv = (tv >= s.den);
        r.rem_u = bu ? (tu - s.den) : tu;
        r.rem_v = bv ? (tv - s.den) : tv;
        r.quo_u = {s.quo_u[cmup_pkg::COORD_BITS-2:0], bu};
        r.quo_v = {s.quo_v[cmup_pkg::COORD_BITS-2:0], bv};
        return r;
    endfunction

    // Map a signed quotient onto the coordinate range, saturating at the top
    function automatic logic [cmup_pkg::COORD_BITS-1:0] to_coord(
        logic [cmup_pkg::COORD_BITS-1:0] q, logic neg);
        logic [cmup_pkg::COORD_BITS:0] sum;
        sum = neg ? ({1'b0, cmup_pkg::CENTRE} - {1'b0, q})
                  : ({1'b0, cmup_pkg::CENTRE} + {1'b0, q});
        return sum[cmup_pkg::COORD_BITS] ? cmup_pkg::COORD_TOP
                                         : sum[cmup_pkg::COORD_BITS-1:0];
    endfunction

    // Advance a stage when it is empty or the one after it advances
    always_comb
    begin
        adv[LAST+1] = !out_valid_reg || tex_ready;
        for (int i = LAST; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign vec_ready = adv[0];

    // Front stage: magnitudes, dominant axis, numerators and their signs
    always_comb
    begin
        logic                          xn;
        logic                          yn;
        logic                          zn;
        logic [cmup_pkg::COMP_BITS-1:0] ax;
        logic [cmup_pkg::COMP_BITS-1:0] ay;
        logic [cmup_pkg::COMP_BITS-1:0] az;
        xn = vec.vec_x[cmup_pkg::COMP_BITS-1];
        yn = vec.vec_y[cmup_pkg::COMP_BITS-1];
        zn = vec.vec_z[cmup_pkg::COMP_BITS-1];
        ax = xn ? (~vec.vec_x + 1'b1) : vec.vec_x;
        ay = yn ? (~vec.vec_y + 1'b1) : vec.vec_y;
        az = zn ? (~vec.vec_z + 1'b1) : vec.vec_z;
        front_next       = '0;
        front_next.zero  = (ax == '0) && (ay == '0) && (az == '0);
        priority if (ax >= ay && ax >= az)
        begin
            front_next.den   = ax;
            front_next.rem_u = az;
            front_next.neg_u = ~(xn ^ zn);
            front_next.rem_v = ay;
            front_next.neg_v = yn;
        end
        else if (ay >= az)
        begin
            front_next.den   = ay;
            front_next.rem_u = ax;
            front_next.neg_u = xn;
            front_next.rem_v = az;
            front_next.neg_v = ~(yn ^ zn);
        end
        else
        begin
            front_next.den   = az;
            front_next.rem_u = ax;
            front_next.neg_u = xn ^ zn;
            front_next.rem_v = ay;
            front_next.neg_v = yn;
        end
    end

    // Output mapping
    always_comb
    begin
        out_next.zero_vector = stage_reg[LAST].zero;
        if (stage_reg[LAST].zero)
        begin
            out_next.tex_u = cmup_pkg::CENTRE;
            out_next.tex_v = cmup_pkg::CENTRE;
        end
        else
        begin
            out_next.tex_u = to_coord(stage_reg[LAST].quo_u, stage_reg[LAST].neg_u);
            out_next.tex_v = to_coord(stage_reg[LAST].quo_v, stage_reg[LAST].neg_v);
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= vec_valid;
            end
            for (int i = 1; i <= LAST; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
            if (adv[LAST+1])
            begin
                out_valid_reg <= valid_reg[LAST];
            end
        end
    end

    // Stage payloads: load on a transfer into the stage
    always_ff @(posedge clk)
    begin
        if (adv[0] && vec_valid)
        begin
            stage_reg[0] <= front_next;
        end
        for (int i = 1; i <= LAST; i++)
        begin
            if (adv[i] && valid_reg[i-1])
            begin
                stage_reg[i] <= div_step(stage_reg[i-1], i == 1);
            end
        end
        if (adv[LAST+1] && valid_reg[LAST])
        begin
            out_reg <= out_next;
        end
    end

    assign tex_valid = out_valid_reg;
    assign tex       = out_reg;

    // A zero vector always leaves at the face center
    assert property (@(posedge clk) disable iff (!rst_n)
        tex_valid && tex.zero_vector |->
            tex.tex_u == cmup_pkg::CENTRE && tex.tex_v == cmup_pkg::CENTRE)
        else $error("zero vector result is not the face center");

    // Quotients never exceed one whole
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !stage_reg[LAST].zero |->
            stage_reg[LAST].quo_u <= cmup_pkg::CENTRE &&
            stage_reg[LAST].quo_v <= cmup_pkg::CENTRE)
        else $error("quotient out of range");

    // Remainders stay below the divisor after the division steps
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !stage_reg[LAST].zero |->
            stage_reg[LAST].rem_u < stage_reg[LAST].den &&
            stage_reg[LAST].rem_v < stage_reg[LAST].den)
        else $error("division remainder not below divisor");

    // A nonzero vector has a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !stage_reg[0].zero |-> stage_reg[0].den != '0)
        else $error("zero divisor for a nonzero vector");

endmodule

>>> bench/tb_cube_map_uv_projection_top.sv
module tb_cube_map_uv_projection_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int DRAIN_CYCLES     = cmup_pkg::DIV_STAGES + 12;

    typedef struct {
        cmup_pkg::vec_t v;
        bit             typed;
        cmup_pkg::tex_t want;
    } dir_row_t;

    logic           clk;
    logic           rst_n;
    logic           vec_valid;
    logic           vec_ready;
    cmup_pkg::vec_t vec;
    logic           tex_valid;
    logic           tex_ready;
    cmup_pkg::tex_t tex;

    int             src_idle    = 28;
    int             snk_idle    = 64;
    int             error_count = 0;
    cmup_pkg::tex_t pending_tex[$];

    // Directed vectors: typed rows carry their own answer, the rest go to the predictor
    dir_row_t dir_rows [25] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b1}},
        '{'{16'sd32767, 16'sd0, 16'sd0}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b0}},
        '{'{-16'sd32767, 16'sd0, 16'sd0}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b0}},
        '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b0}},
        '{'{16'sd0, 16'sd0, -16'sd32767}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b0}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
          '{'0, cmup_pkg::COORD_TOP, 1'b0}},
        '{'{-16'sd32767, -16'sd32767, -16'sd32767}, 1'b1, '{'0, '0, 1'b0}},
        '{'{16'sh8000, 16'sd0, 16'sd0}, 1'b1,
          '{cmup_pkg::CENTRE, cmup_pkg::CENTRE, 1'b0}},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1, '{'0, '0, 1'b0}},
        '{'{16'sd1000, 16'sd2000, 16'sd500}, 1'b0, '0},
        '{'{16'sd1000, -16'sd2000, 16'sd500}, 1'b0, '0},
        '{'{16'sd300, 16'sd200, 16'sd1000}, 1'b0, '0},
        '{'{16'sd300, 16'sd200, -16'sd1000}, 1'b0, '0},
        '{'{-16'sd1000, 16'sd200, 16'sd300}, 1'b0, '0},
        '{'{16'sd1000, 16'sd200, -16'sd300}, 1'b0, '0},
        '{'{16'sd500, 16'sd500, 16'sd100}, 1'b0, '0},
        '{'{16'sd100, -16'sd500, 16'sd500}, 1'b0, '0},
        '{'{-16'sd500, 16'sd100, 16'sd500}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd1}, 1'b0, '0},
        '{'{16'sd0, -16'sd1, 16'sd0}, 1'b0, '0},
        '{'{16'sd3, 16'sd1, 16'sd2}, 1'b0, '0},
        '{'{16'sd3, -16'sd1, -16'sd2}, 1'b0, '0},
        '{'{16'sd0, 16'sh8000, 16'sd32767}, 1'b0, '0},
        '{'{16'sd32767, -16'sd32767, 16'sd0}, 1'b0, '0},
        '{'{-16'sd32767, 16'sd32767, -16'sd32767}, 1'b0, '0}
    };

    cube_map_uv_projection_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec       (vec),
        .tex_valid (tex_valid),
        .tex_ready (tex_ready),
        .tex       (tex)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Map one numerator over the dominant magnitude onto the face range
    function automatic logic [cmup_pkg::COORD_BITS-1:0] face_coord(longint num, longint den);
        longint mid;
        longint top;
        longint c;
        mid = longint'(1) << (cmup_pkg::COORD_BITS - 1);
        top = (longint'(1) << cmup_pkg::COORD_BITS) - 1;
        c   = mid + (num * mid) / den;
        if (c > top)
            c = top;
        if (c < 0)
            c = 0;
        return cmup_pkg::COORD_BITS'(c);
    endfunction

    // Pick the dominant axis (ties to X, then Y) and project the other two
    function automatic cmup_pkg::tex_t project_dir(cmup_pkg::vec_t v);
        longint         x, y, z, ax, ay, az, nu, nv, d;
        cmup_pkg::tex_t t;
        x  = longint'($signed(v.vec_x));
        y  = longint'($signed(v.vec_y));
        z  = longint'($signed(v.vec_z));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            t.tex_u       = cmup_pkg::CENTRE;
            t.tex_v       = cmup_pkg::CENTRE;
            t.zero_vector = 1'b1;
            return t;
        end
        if (ax >= ay && ax >= az)
        begin
            d  = ax;
            nu = (x < 0) ? z : -z;
            nv = y;
        end
        else if (ay >= az)
        begin
            d  = ay;
            nu = x;
            nv = (y < 0) ? z : -z;
        end
        else
        begin
            d  = az;
            nu = (z < 0) ? -x : x;
            nv = y;
        end
        t.tex_u       = face_coord(nu, d);
        t.tex_v       = face_coord(nv, d);
        t.zero_vector = 1'b0;
        return t;
    endfunction

    function automatic logic [cmup_pkg::COMP_BITS-1:0] signed_mag(int m);
        return ($urandom_range(0, 1) != 0) ? cmup_pkg::COMP_BITS'(-m)
                                           : cmup_pkg::COMP_BITS'(m);
    endfunction

    // Draw a vector: mostly full range, with ties, extremes, tiny and zero vectors mixed in
    function automatic cmup_pkg::vec_t random_vec();
        logic [cmup_pkg::COMP_BITS-1:0] c [3];
        cmup_pkg::vec_t                 r;
        int kind;
        int idx;
        int m;
        kind = $urandom_range(0, 9);
        idx  = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            c[i] = cmup_pkg::COMP_BITS'($urandom);
        case (kind)
            4:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = cmup_pkg::COMP_BITS'(int'($urandom_range(0, 14)) - 7);
            end
            5:
            begin
                m = $urandom_range(1, 32767);
                for (int i = 0; i < 3; i++)
                    c[i] = signed_mag(m);
                if ($urandom_range(0, 3) != 0)
                    c[idx] = signed_mag($urandom_range(0, m - 1));
            end
            6:
            begin
                case ($urandom_range(0, 2))
                    0: c[idx] = cmup_pkg::COMP_BITS'(32767);
                    1: c[idx] = cmup_pkg::COMP_BITS'(-32767);
                    default: c[idx] = cmup_pkg::COMP_BITS'(-32768);
                endcase
            end
            7:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = '0;
                if ($urandom_range(0, 1) != 0)
                    c[idx] = signed_mag($urandom_range(1, 32768));
            end
            default:
            begin
            end
        endcase
        r.vec_x = c[0];
        r.vec_y = c[1];
        r.vec_z = c[2];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Offer one vector after a random gap and hold it until the transfer
    task automatic send_vec(input cmup_pkg::vec_t v, input cmup_pkg::tex_t want);
        while ($urandom_range(99) < src_idle)
        begin
            vec_valid <= 1'b0;
            @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec       <= v;
        do
            @(posedge clk);
        while (!vec_ready);
        pending_tex = {pending_tex, want};
    endtask

    // Stall the result side at random
    always @(posedge clk)
        tex_ready <= ($urandom_range(99) >= snk_idle);

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : tex_check
        cmup_pkg::tex_t want;
        if (rst_n && tex_valid && tex_ready)
        begin
            if (pending_tex.size() == 0)
                flag_mismatch($sformatf("unexpected result u=%0d v=%0d zero=%0b",
                                        tex.tex_u, tex.tex_v, tex.zero_vector));
            else
            begin
                want = pending_tex.pop_front();
                if (tex.tex_u !== want.tex_u)
                    flag_mismatch($sformatf("tex_u %0d, expected %0d",
                                            tex.tex_u, want.tex_u));
                if (tex.tex_v !== want.tex_v)
                    flag_mismatch($sformatf("tex_v %0d, expected %0d",
                                            tex.tex_v, want.tex_v));
                if (tex.zero_vector !== want.zero_vector)
                    flag_mismatch($sformatf("zero_vector %0b, expected %0b",
                                            tex.zero_vector, want.zero_vector));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_cube_map_uv_projection_top: errors");
        $finish;
    end

    initial
    begin
        cmup_pkg::vec_t v;
        rst_n     = 1'b0;
        vec_valid = 1'b0;
        vec       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender lightly idle, receiver mostly stalled
        src_idle = 28;
        snk_idle = 64;
        foreach (dir_rows[i])
            send_vec(dir_rows[i].v,
                     dir_rows[i].typed ? dir_rows[i].want : project_dir(dir_rows[i].v));
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            v = random_vec();
            send_vec(v, project_dir(v));
        end

        // Swap the roles
        src_idle = 64;
        snk_idle = 28;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            v = random_vec();
            send_vec(v, project_dir(v));
        end

        // Full rate on both sides
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            v = random_vec();
            send_vec(v, project_dir(v));
        end
        vec_valid <= 1'b0;

        // Drain the pipeline, then watch for stray results
        while (pending_tex.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_cube_map_uv_projection_top: clean");
        else
            $display("tb_cube_map_uv_projection_top: errors");
        $finish;
    end

endmodule

>>> cube_map_uv_projection_top.f
hdl/cmup_pkg.sv
hdl/cube_map_uv_projection_top.sv
bench/tb_cube_map_uv_projection_top.sv
